FILE: design/direction_rotate_convert_core_macros.svh
// Assertion macros shared by the direction unit.
`ifndef DIRECTION_ROTATE_CONVERT_CORE_MACROS_SVH
`define DIRECTION_ROTATE_CONVERT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// cons holds in the same cycle as ante
`define DRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("direction unit check failed");
// cons holds in the cycle after ante
`define DRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("direction unit check failed");
`else
`define DRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/drc_pkg.sv
// Shared types, constants and tables of the direction unit.
package drc_pkg;

    localparam int CORDIC_STEPS   = 30;
    localparam int SQRT_STEPS     = 32;
    localparam int DIV_STEPS      = 17;
    localparam int CX_W           = 36;
    localparam int CZ_W           = 34;
    localparam int V_W            = 34;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 24;

    localparam logic REQ_CONVERT = 1'b0;
    localparam logic REQ_ROTATE  = 1'b1;

    localparam logic signed [CX_W-1:0] INV_GAIN  = 36'sd652032874;
    localparam logic signed [CZ_W-1:0] HALF_ZW   = 34'sd2147483648;
    localparam logic [31:0]            HALF_TURN = 32'h8000_0000;

    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933405, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335086,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721, 30'd20860,
        30'd10430, 30'd5215, 30'd2607, 30'd1303, 30'd651, 30'd325, 30'd162,
        30'd81, 30'd40, 30'd20, 30'd10, 30'd5, 30'd2, 30'd1
    };

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } sqrt_t;

    typedef struct packed {
        logic [47:0]          rem;
        logic [31:0]          den;
        logic [DIV_STEPS-1:0] q;
    } quo_t;

    typedef struct packed {
        logic                  rotate;
        axis_t                 axis;
        logic signed [V_W-1:0] vx;
        logic signed [V_W-1:0] vy;
        logic signed [V_W-1:0] vz;
        logic [2:0]            neg;
    } front_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zero;
        logic               zaxis;
    } norm_t;

    typedef struct packed {
        logic       zero;
        logic       zaxis;
        logic       zneg;
        logic [2:0] sgn;
    } tail_t;

    // quadrants 1 and 2 fold by a half turn
    function automatic logic sc_neg(logic [31:0] a);
        return a[31] ^ a[30];
    endfunction

    function automatic cordic_t sc_seed(logic [31:0] a);
        cordic_t     s;
        logic [31:0] af;
        af = sc_neg(a) ? {~a[31], a[30:0]} : a;
        s.x = INV_GAIN;
        s.y = '0;
        s.z = CZ_W'($signed(af));
        return s;
    endfunction

endpackage

FILE: design/drc_cordic_cell.sv
// One CORDIC micro-rotation step, rotation or vectoring form.
module drc_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic             clk,
    input  logic             en,
    input  drc_pkg::cordic_t d,
    output drc_pkg::cordic_t q
);

    drc_pkg::cordic_t q_reg, q_next;
    logic signed [drc_pkg::CX_W-1:0] xs, ys;
    logic signed [drc_pkg::CZ_W-1:0] at;
    logic sigma;

    always_comb
    begin
        xs = d.x >>> STEP;
        ys = d.y >>> STEP;
        at = $signed(drc_pkg::CZ_W'(drc_pkg::ATAN_TAB[STEP]));
        // drive y toward zero, or z toward zero
        sigma = VECTOR ? (d.y <= 0) : (d.z >= 0);
        if (sigma)
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - at;
        end
        else
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: design/drc_sqrt_cell.sv
// One digit step of the integer square root.
module drc_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           en,
    input  drc_pkg::sqrt_t d,
    output drc_pkg::sqrt_t q
);

    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

    drc_pkg::sqrt_t q_reg, q_next;
    logic [64:0] trial;
    logic        ge;

    always_comb
    begin
        trial = {1'b0, d.res} + {1'b0, BIT};
        ge = {1'b0, d.n} >= trial;
        q_next.n   = ge ? d.n - trial[63:0] : d.n;
        q_next.res = ge ? (d.res >> 1) + BIT : d.res >> 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: design/drc_div_cell.sv
// One quotient bit of a restoring division.
module drc_div_cell #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          en,
    input  drc_pkg::quo_t d,
    output drc_pkg::quo_t q
);

    localparam int QB = drc_pkg::DIV_STEPS - 1 - STEP;

    drc_pkg::quo_t q_reg, q_next;
    logic [48:0] dsh;
    logic        ge;

    always_comb
    begin
        dsh = 49'(d.den) << QB;
        ge = {1'b0, d.rem} >= dsh;
        q_next.den = d.den;
        q_next.rem = ge ? d.rem - dsh[47:0] : d.rem;
        q_next.q   = ge ? d.q | (drc_pkg::DIV_STEPS'(1) << QB) : d.q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: design/direction_rotate_convert_core.sv
// Throughput: one request per cycle through a fully pipelined chain of cells
// (30-step CORDIC chains, 32-step square root chains, 17-step dividers).
// The whole chain holds while a finished result waits on out_ready.
// Reset clears the stage valid bits only; the data path is not reset.
`include "direction_rotate_convert_core_macros.svh"

module direction_rotate_convert_core #(
    parameter int ANGLE_BITS = drc_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = drc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic signed [COORD_BITS-1:0] vec_x,
    input  logic signed [COORD_BITS-1:0] vec_y,
    input  logic signed [COORD_BITS-1:0] vec_z,
    input  logic [ANGLE_BITS-1:0]        zenith_in,
    input  logic [ANGLE_BITS-1:0]        azimuth_in,
    input  logic [1:0]                   rot_axis,
    input  logic [ANGLE_BITS-1:0]        rot_angle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ANGLE_BITS-1:0]        zenith_out,
    output logic [ANGLE_BITS-1:0]        azimuth_out,
    output logic signed [15:0]           unit_x,
    output logic signed [15:0]           unit_y,
    output logic signed [15:0]           unit_z
);

    localparam int NC   = drc_pkg::CORDIC_STEPS;
    localparam int NS   = drc_pkg::SQRT_STEPS;
    localparam int ND   = drc_pkg::DIV_STEPS;
    localparam int DQ   = NC - ND;
    localparam int VW   = drc_pkg::V_W;
    localparam int XW   = drc_pkg::CX_W;
    localparam int ASH  = 32 - ANGLE_BITS;
    localparam logic [32:0] ARND = (33'(1) << ASH) >> 1;
    localparam int LAT  = 1 + NC + 8 + NS + 1 + NC + 1;
    localparam int ST_N2 = 1 + NC + 4;
    localparam int ST_SQ = 1 + NC + 7 + NS;

    logic [LAT-1:0] vld_reg;
    logic           adv;

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // ---------------- request register and sine/cosine chains ----------------
    logic [31:0]      ang [3];
    drc_pkg::front_t  front_next;
    drc_pkg::front_t  front_reg [NC+1];
    drc_pkg::cordic_t sc_seed_reg [3];
    drc_pkg::cordic_t sc_w [3][NC+1];

    always_comb
    begin
        ang[0] = 32'(zenith_in) << ASH;
        ang[1] = 32'(azimuth_in) << ASH;
        ang[2] = 32'(rot_angle) << ASH;
        front_next.rotate = req_type;
        front_next.axis   = drc_pkg::axis_t'(rot_axis);
        front_next.vx     = VW'(vec_x);
        front_next.vy     = VW'(vec_y);
        front_next.vz     = VW'(vec_z);
        front_next.neg    = {drc_pkg::sc_neg(ang[2]), drc_pkg::sc_neg(ang[1]),
                             drc_pkg::sc_neg(ang[0])};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg[0] <= front_next;
            for (int k = 0; k < 3; k++)
            begin
                sc_seed_reg[k] <= drc_pkg::sc_seed(ang[k]);
            end
            for (int j = 1; j <= NC; j++)
            begin
                front_reg[j] <= front_reg[j-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_sc
        assign sc_w[k][0] = sc_seed_reg[k];
        for (genvar i = 0; i < NC; i++)
        begin : g_cell
            drc_cordic_cell #(.STEP(i), .VECTOR(1'b0)) u_cell (
                .clk (clk),
                .en  (adv),
                .d   (sc_w[k][i]),
                .q   (sc_w[k][i+1])
            );
        end
    end

    // ---------------- direction vector and rotation ----------------
    logic signed [31:0] cs [3];
    logic signed [31:0] sn [3];
    logic signed [63:0] psx_reg, psy_reg;
    logic signed [31:0] cz_reg, cr_reg, sr_reg;
    drc_pkg::front_t    f31_reg, f32_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cs[k] = 32'(front_reg[NC].neg[k] ? -sc_w[k][NC].x : sc_w[k][NC].x);
            sn[k] = 32'(front_reg[NC].neg[k] ? -sc_w[k][NC].y : sc_w[k][NC].y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            psx_reg <= sn[0] * cs[1];
            psy_reg <= sn[0] * sn[1];
            cz_reg  <= cs[0];
            cr_reg  <= cs[2];
            sr_reg  <= sn[2];
            f31_reg <= front_reg[NC];
        end
    end

    logic signed [31:0] ux, uy, uz, tv, uv;
    logic signed [63:0] pct_reg, psu_reg, pst_reg, pcu_reg;
    logic signed [31:0] x32_reg, y32_reg, z32_reg;

    always_comb
    begin
        ux = 32'(-(psx_reg >>> 30));
        uy = 32'(-(psy_reg >>> 30));
        uz = -cz_reg;
        case (f31_reg.axis)
            drc_pkg::AXIS_X:
            begin
                tv = uy;
                uv = uz;
            end
            drc_pkg::AXIS_Y:
            begin
                tv = uz;
                uv = ux;
            end
            default:
            begin
                tv = ux;
                uv = uy;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pct_reg <= cr_reg * tv;
            psu_reg <= sr_reg * uv;
            pst_reg <= sr_reg * tv;
            pcu_reg <= cr_reg * uv;
            x32_reg <= ux;
            y32_reg <= uy;
            z32_reg <= uz;
            f32_reg <= f31_reg;
        end
    end

    logic signed [VW-1:0] ra, rb;
    logic signed [VW-1:0] rv [3];
    logic signed [VW-1:0] v33_reg [3];

    always_comb
    begin
        ra = VW'((pct_reg - psu_reg) >>> 30);
        rb = VW'((pst_reg + pcu_reg) >>> 30);
        rv[0] = VW'(x32_reg);
        rv[1] = VW'(y32_reg);
        rv[2] = VW'(z32_reg);
        case (f32_reg.axis)
            drc_pkg::AXIS_X:
            begin
                rv[1] = ra;
                rv[2] = rb;
            end
            drc_pkg::AXIS_Y:
            begin
                rv[2] = ra;
                rv[0] = rb;
            end
            drc_pkg::AXIS_Z:
            begin
                rv[0] = ra;
                rv[1] = rb;
            end
            default:
            begin
                rv[0] = VW'(x32_reg);
            end
        endcase
        if (f32_reg.rotate == drc_pkg::REQ_CONVERT)
        begin
            rv[0] = f32_reg.vx;
            rv[1] = f32_reg.vy;
            rv[2] = f32_reg.vz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v33_reg[k] <= rv[k];
            end
        end
    end

    // ---------------- normalize to [2^30, 2^31) ----------------
    logic signed [VW-1:0] sh1 [3];
    logic signed [VW-1:0] sh2 [3];
    logic [VW-1:0] m0, m1, m2, a0, a1, a2;
    logic signed [31:0] v34_next [3];
    logic [30:0]        m34_next;
    logic signed [31:0] v34_reg [3];
    logic [30:0]        m34_reg;
    logic               zero34_reg;

    always_comb
    begin
        m0 = '0;
        m1 = '0;
        m2 = '0;
        for (int k = 0; k < 3; k++)
        begin
            sh1[k] = v33_reg[k] >>> 1;
            sh2[k] = v33_reg[k] >>> 2;
            a0 = v33_reg[k] < 0 ? -v33_reg[k] : v33_reg[k];
            a1 = sh1[k] < 0 ? -sh1[k] : sh1[k];
            a2 = sh2[k] < 0 ? -sh2[k] : sh2[k];
            if (a0 > m0) m0 = a0;
            if (a1 > m1) m1 = a1;
            if (a2 > m2) m2 = a2;
        end
        for (int k = 0; k < 3; k++)
        begin
            if (m0 < VW'(drc_pkg::HALF_TURN))
                v34_next[k] = 32'(v33_reg[k]);
            else if (m1 < VW'(drc_pkg::HALF_TURN))
                v34_next[k] = 32'(sh1[k]);
            else
                v34_next[k] = 32'(sh2[k]);
        end
        if (m0 < VW'(drc_pkg::HALF_TURN))
            m34_next = 31'(m0);
        else if (m1 < VW'(drc_pkg::HALF_TURN))
            m34_next = 31'(m1);
        else
            m34_next = 31'(m2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v34_reg    <= v34_next;
            m34_reg    <= m34_next;
            zero34_reg <= (m0 == '0);
        end
    end

    logic [4:0]         lsh;
    logic signed [31:0] v35_reg [3];
    logic [30:0]        m35_reg;
    logic [4:0]         l35_reg;
    logic               zero35_reg;

    always_comb
    begin
        lsh = '0;
        for (int b = 0; b < 31; b++)
        begin
            if (m34_reg[b]) lsh = 5'(30 - b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v35_reg    <= v34_reg;
            m35_reg    <= m34_reg;
            l35_reg    <= lsh;
            zero35_reg <= zero34_reg;
        end
    end

    logic [30:0]      m_norm;
    drc_pkg::norm_t   n36_reg, n37_reg, n36_next;

    always_comb
    begin
        m_norm         = m35_reg << l35_reg;
        n36_next.x     = v35_reg[0] <<< l35_reg;
        n36_next.y     = v35_reg[1] <<< l35_reg;
        n36_next.z     = v35_reg[2] <<< l35_reg;
        n36_next.zero  = zero35_reg;
        n36_next.zaxis = (v35_reg[0] == '0) && (v35_reg[1] == '0);
    end

    // ---------------- squares and square roots ----------------
    logic [63:0] sqx_reg, sqy_reg, sqz_reg;
    logic [63:0] rho_sum, r_sum;
    drc_pkg::sqrt_t sq_seed_reg [2];
    drc_pkg::sqrt_t sq_w [2][NS+1];
    drc_pkg::norm_t nside_reg [NS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n36_reg <= n36_next;
            sqx_reg <= 64'(n36_reg.x * n36_reg.x);
            sqy_reg <= 64'(n36_reg.y * n36_reg.y);
            sqz_reg <= 64'(n36_reg.z * n36_reg.z);
            n37_reg <= n36_reg;
            sq_seed_reg[0] <= '{n: r_sum, res: 64'd0};
            sq_seed_reg[1] <= '{n: rho_sum, res: 64'd0};
            nside_reg[0]   <= n37_reg;
            for (int j = 1; j <= NS; j++)
            begin
                nside_reg[j] <= nside_reg[j-1];
            end
        end
    end

    assign rho_sum = sqx_reg + sqy_reg;
    assign r_sum   = rho_sum + sqz_reg;

    for (genvar k = 0; k < 2; k++)
    begin : g_sq
        assign sq_w[k][0] = sq_seed_reg[k];
        for (genvar i = 0; i < NS; i++)
        begin : g_cell
            drc_sqrt_cell #(.STEP(i)) u_cell (
                .clk (clk),
                .en  (adv),
                .d   (sq_w[k][i]),
                .q   (sq_w[k][i+1])
            );
        end
    end

    // ---------------- angle chains and dividers ----------------
    drc_pkg::norm_t     nf;
    logic [31:0]        rr, rho;
    logic signed [XW-1:0] zx, zy, axx, ayy;
    drc_pkg::cordic_t   vz_next, va_next;
    logic signed [31:0] vv [3];
    logic [30:0]        vm;
    drc_pkg::quo_t      dv_next [3];
    drc_pkg::tail_t     tail_next;

    always_comb
    begin
        nf  = nside_reg[NS];
        rr  = sq_w[0][NS].res[31:0];
        rho = sq_w[1][NS].res[31:0];
        zx  = -XW'(nf.z);
        zy  = $signed(XW'(rho));
        axx = -XW'(nf.x);
        ayy = -XW'(nf.y);
        // left half plane: turn by a half turn first
        if (zx < 0)
            vz_next = '{x: -zx, y: -zy, z: drc_pkg::HALF_ZW};
        else
            vz_next = '{x: zx, y: zy, z: '0};
        if (axx < 0)
            va_next = '{x: -axx, y: -ayy, z: drc_pkg::HALF_ZW};
        else
            va_next = '{x: axx, y: ayy, z: '0};
        vv[0] = nf.x;
        vv[1] = nf.y;
        vv[2] = nf.z;
        for (int k = 0; k < 3; k++)
        begin
            vm = 31'(vv[k] < 0 ? -vv[k] : vv[k]);
            dv_next[k].rem = 48'({vm, 15'd0}) + 48'(rr >> 1);
            dv_next[k].den = rr;
            dv_next[k].q   = '0;
        end
        tail_next.zero  = nf.zero;
        tail_next.zaxis = nf.zaxis;
        tail_next.zneg  = nf.z < 0;
        tail_next.sgn   = {nf.z < 0, nf.y < 0, nf.x < 0};
    end

    drc_pkg::cordic_t   vz_seed_reg, va_seed_reg;
    drc_pkg::cordic_t   vz_w [NC+1];
    drc_pkg::cordic_t   va_w [NC+1];
    drc_pkg::quo_t      dv_seed_reg [3];
    drc_pkg::quo_t      dv_w [3][ND+1];
    logic [ND-1:0]      qdel_reg [3][DQ];
    drc_pkg::tail_t     tail_reg [NC+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vz_seed_reg <= vz_next;
            va_seed_reg <= va_next;
            dv_seed_reg <= dv_next;
            tail_reg[0] <= tail_next;
            for (int j = 1; j <= NC; j++)
            begin
                tail_reg[j] <= tail_reg[j-1];
            end
            for (int k = 0; k < 3; k++)
            begin
                qdel_reg[k][0] <= dv_w[k][ND].q;
                for (int j = 1; j < DQ; j++)
                begin
                    qdel_reg[k][j] <= qdel_reg[k][j-1];
                end
            end
        end
    end

    assign vz_w[0] = vz_seed_reg;
    assign va_w[0] = va_seed_reg;

    for (genvar i = 0; i < NC; i++)
    begin : g_vec
        drc_cordic_cell #(.STEP(i), .VECTOR(1'b1)) u_zen (
            .clk (clk),
            .en  (adv),
            .d   (vz_w[i]),
            .q   (vz_w[i+1])
        );
        drc_cordic_cell #(.STEP(i), .VECTOR(1'b1)) u_az (
            .clk (clk),
            .en  (adv),
            .d   (va_w[i]),
            .q   (va_w[i+1])
        );
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        assign dv_w[k][0] = dv_seed_reg[k];
        for (genvar i = 0; i < ND; i++)
        begin : g_cell
            drc_div_cell #(.STEP(i)) u_cell (
                .clk (clk),
                .en  (adv),
                .d   (dv_w[k][i]),
                .q   (dv_w[k][i+1])
            );
        end
    end

    // ---------------- result register ----------------
    drc_pkg::tail_t  tf;
    logic [31:0]     zen, az;
    logic [32:0]     zen_rnd, az_rnd;
    logic [ND-1:0]   qf;
    logic signed [15:0] unit_next [3];
    logic [ANGLE_BITS-1:0] zen_reg, az_reg;
    logic signed [15:0]    unit_reg [3];

    always_comb
    begin
        tf = tail_reg[NC];
        if (vz_w[NC].z < 0)
            zen = '0;
        else if (vz_w[NC].z > drc_pkg::HALF_ZW)
            zen = drc_pkg::HALF_TURN;
        else
            zen = vz_w[NC].z[31:0];
        az = va_w[NC].z[31:0];
        if (tf.zero || tf.zaxis)
        begin
            az  = drc_pkg::HALF_TURN;
            zen = (tf.zaxis && !tf.zero && tf.zneg) ? 32'd0 : drc_pkg::HALF_TURN;
        end
        zen_rnd = {1'b0, zen} + ARND;
        az_rnd  = {1'b0, az} + ARND;
        for (int k = 0; k < 3; k++)
        begin
            qf = qdel_reg[k][DQ-1];
            if (tf.zero)
                unit_next[k] = '0;
            else if (tf.sgn[k])
                unit_next[k] = -16'((qf > ND'(32768)) ? ND'(32768) : qf);
            else
                unit_next[k] = 16'((qf > ND'(32767)) ? ND'(32767) : qf);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zen_reg  <= ANGLE_BITS'(zen_rnd >> ASH);
            az_reg   <= ANGLE_BITS'(az_rnd >> ASH);
            unit_reg <= unit_next;
        end
    end

    assign zenith_out  = zen_reg;
    assign azimuth_out = az_reg;
    assign unit_x      = unit_reg[0];
    assign unit_y      = unit_reg[1];
    assign unit_z      = unit_reg[2];

    `DRC_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && !out_ready, out_valid)
    `DRC_ASSERT_NOW(a_zenith_range, clk, rst_n, out_valid, zenith_out <= (ANGLE_BITS'(1) << (ANGLE_BITS - 1)))
    `DRC_ASSERT_NOW(a_norm_msb, clk, rst_n, vld_reg[ST_N2] && !zero35_reg, m_norm[30])
    `DRC_ASSERT_NOW(a_root_order, clk, rst_n, vld_reg[ST_SQ], sq_w[0][NS].res >= sq_w[1][NS].res)

endmodule

FILE: tb/direction_rotate_convert_core_test.sv
// Self-checking testbench of the direction unit: directed table, then random requests.
module direction_rotate_convert_core_test;

    localparam int  ABITS = 16;
    localparam int  CBITS = 24;
    localparam longint TURN_HALF = 64'sd2147483648;

    typedef struct packed {
        logic [15:0]        zen;
        logic [15:0]        az;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
    } dir_res_t;

    typedef struct {
        logic                     kind;
        logic signed [CBITS-1:0]  x;
        logic signed [CBITS-1:0]  y;
        logic signed [CBITS-1:0]  z;
        logic [ABITS-1:0]         zen;
        logic [ABITS-1:0]         az;
        drc_pkg::axis_t           axis;
        logic [ABITS-1:0]         ang;
        bit                       fixed;
        dir_res_t                 res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic req_type;
    logic signed [CBITS-1:0] vec_x;
    logic signed [CBITS-1:0] vec_y;
    logic signed [CBITS-1:0] vec_z;
    logic [ABITS-1:0] zenith_in;
    logic [ABITS-1:0] azimuth_in;
    logic [1:0] rot_axis;
    logic [ABITS-1:0] rot_angle;
    logic out_valid;
    logic out_ready;
    logic [ABITS-1:0] zenith_out;
    logic [ABITS-1:0] azimuth_out;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;

    dir_res_t pending_dirs[$];
    int       mismatches;
    bit       steady;

    longint atan_step[30] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443,
        41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
        10, 5, 2, 1
    };

    direction_rotate_convert_core DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .zenith_in(zenith_in), .azimuth_in(azimuth_in), .rot_axis(rot_axis),
        .rot_angle(rot_angle), .out_valid(out_valid), .out_ready(out_ready),
        .zenith_out(zenith_out), .azimuth_out(azimuth_out),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z)
    );

    function automatic longint vector_angle(longint x, longint y);
        longint acc;
        longint nx;
        acc = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = TURN_HALF;
        end
        for (int i = 0; i < 30; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                acc += atan_step[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                acc -= atan_step[i];
            end
            x = nx;
        end
        return acc;
    endfunction

    function automatic void sine_cosine(input logic [31:0] a, output longint c,
                                        output longint s);
        longint x;
        longint y;
        longint z;
        longint nx;
        int     sa;
        bit     neg;
        x = 652032874;
        y = 0;
        neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (neg)
            a = a - 32'h8000_0000;
        sa = a;
        z = sa;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_step[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_step[i];
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] round_angle(longint unsigned a);
        return 16'((a + 64'd32768) >> 16);
    endfunction

    function automatic logic [15:0] unit_of(longint v, longint unsigned r);
        longint unsigned q;
        longint unsigned m;
        m = (v < 0) ? -v : v;
        q = (m * 32768 + r / 2) / r;
        if (v < 0)
            return 16'(-longint'((q > 32768) ? 32768 : q));
        return 16'((q > 32767) ? 32767 : q);
    endfunction

    function automatic longint peak3(longint x, longint y, longint z);
        longint m;
        m = (x < 0) ? -x : x;
        if (((y < 0) ? -y : y) > m) m = (y < 0) ? -y : y;
        if (((z < 0) ? -z : z) > m) m = (z < 0) ? -z : z;
        return m;
    endfunction

    function automatic dir_res_t spherical_of(longint x, longint y, longint z);
        dir_res_t        d;
        longint          m;
        longint          zen;
        longint unsigned rho;
        longint unsigned r;
        longint unsigned az;
        m = peak3(x, y, z);
        if (m == 0)
        begin
            d.zen = round_angle(TURN_HALF);
            d.az = round_angle(TURN_HALF);
            d.ux = '0;
            d.uy = '0;
            d.uz = '0;
            return d;
        end
        while (m >= TURN_HALF)
        begin
            x = x >>> 1;
            y = y >>> 1;
            z = z >>> 1;
            m = peak3(x, y, z);
        end
        while (m < (64'sd1 << 30))
        begin
            x *= 2;
            y *= 2;
            z *= 2;
            m *= 2;
        end
        rho = longint'(unsigned'(x * x)) + longint'(unsigned'(y * y));
        r = int_sqrt(rho + longint'(unsigned'(z * z)));
        rho = int_sqrt(rho);
        if (x == 0 && y == 0)
        begin
            zen = (z < 0) ? 0 : TURN_HALF;
            az = TURN_HALF;
        end
        else
        begin
            zen = vector_angle(-z, longint'(rho));
            if (zen < 0) zen = 0;
            if (zen > TURN_HALF) zen = TURN_HALF;
            az = vector_angle(-x, -y) & 64'hFFFF_FFFF;
        end
        d.zen = round_angle(zen);
        d.az = round_angle(az);
        d.ux = unit_of(x, r);
        d.uy = unit_of(y, r);
        d.uz = unit_of(z, r);
        return d;
    endfunction

    function automatic dir_res_t predict_direction(dir_row_t t);
        longint cz, sz, ca, sa, c, s, x, y, z, h;
        if (t.kind == drc_pkg::REQ_CONVERT)
            return spherical_of(t.x, t.y, t.z);
        sine_cosine({t.zen, 16'h0}, cz, sz);
        sine_cosine({t.az, 16'h0}, ca, sa);
        x = -((sz * ca) >>> 30);
        y = -((sz * sa) >>> 30);
        z = -cz;
        sine_cosine({t.ang, 16'h0}, c, s);
        case (t.axis)
            drc_pkg::AXIS_X:
            begin
                h = y;
                y = (c * h - s * z) >>> 30;
                z = (s * h + c * z) >>> 30;
            end
            drc_pkg::AXIS_Y:
            begin
                h = z;
                z = (c * h - s * x) >>> 30;
                x = (s * h + c * x) >>> 30;
            end
            drc_pkg::AXIS_Z:
            begin
                h = x;
                x = (c * h - s * y) >>> 30;
                y = (s * h + c * y) >>> 30;
            end
            default: ;
        endcase
        return spherical_of(x, y, z);
    endfunction

    function automatic dir_row_t row(logic k, int x, int y, int z, int zn, int az,
                                     drc_pkg::axis_t ax, int ang);
        dir_row_t t;
        t.kind = k;
        t.x = CBITS'(x);
        t.y = CBITS'(y);
        t.z = CBITS'(z);
        t.zen = ABITS'(zn);
        t.az = ABITS'(az);
        t.axis = ax;
        t.ang = ABITS'(ang);
        t.fixed = 1'b0;
        t.res = '0;
        return t;
    endfunction

    function automatic dir_row_t fixed_row(dir_row_t t, dir_res_t r);
        t.fixed = 1'b1;
        t.res = r;
        return t;
    endfunction

    function automatic dir_row_t random_row();
        dir_row_t t;
        int       sel;
        t = row(1'($urandom_range(1, 0)), int'($urandom), int'($urandom),
                int'($urandom), int'($urandom), int'($urandom),
                drc_pkg::axis_t'($urandom_range(3, 0)), int'($urandom));
        sel = int'($urandom_range(9, 0));
        if (t.kind == drc_pkg::REQ_CONVERT)
        begin
            if (sel < 3)
            begin
                t.x = CBITS'(int'($urandom_range(64, 0)) - 32);
                t.y = CBITS'(int'($urandom_range(64, 0)) - 32);
                t.z = CBITS'(int'($urandom_range(64, 0)) - 32);
            end
            else if (sel == 3)
            begin
                t.x = '0;
                t.y = '0;
            end
            else if (sel == 4)
                t.z = '0;
        end
        else if (sel < 8)
            t.zen = ABITS'($urandom_range(32768, 0));
        return t;
    endfunction

    // hold the request until accepted, then queue its expected direction
    task automatic send_request(dir_row_t t);
        if (!steady && $urandom_range(99, 0) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= t.kind;
        vec_x <= t.x;
        vec_y <= t.y;
        vec_z <= t.z;
        zenith_in <= t.zen;
        azimuth_in <= t.az;
        rot_axis <= t.axis;
        rot_angle <= t.ang;
        do
            @(posedge clk);
        while (!in_ready);
        pending_dirs.push_back(t.fixed ? t.res : predict_direction(t));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99, 0) >= 24);
    end

    always @(posedge clk)
    begin
        dir_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dirs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result zen=%0d az=%0d", zenith_out, azimuth_out);
            end
            else
            begin
                e = pending_dirs.pop_front();
                if (zenith_out !== e.zen || azimuth_out !== e.az || unit_x !== e.ux
                    || unit_y !== e.uy || unit_z !== e.uz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected %0d %0d %0d %0d %0d,",
                                  " got %0d %0d %0d %0d %0d"},
                                 e.zen, e.az, e.ux, e.uy, e.uz, zenith_out, azimuth_out,
                                 unit_x, unit_y, unit_z);
                end
            end
        end
    end

    initial
    begin
        #16000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        dir_row_t table_rows[$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        req_type = drc_pkg::REQ_CONVERT;
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        zenith_in = '0;
        azimuth_in = '0;
        rot_axis = drc_pkg::AXIS_X;
        rot_angle = '0;
        mismatches = 0;
        steady = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero vector and the two poles
        table_rows.push_back(fixed_row(
            row(drc_pkg::REQ_CONVERT, 0, 0, 0, 0, 0, drc_pkg::AXIS_X, 0),
            '{16'd32768, 16'd32768, 16'sd0, 16'sd0, 16'sd0}));
        table_rows.push_back(fixed_row(
            row(drc_pkg::REQ_CONVERT, 0, 0, 5, 0, 0, drc_pkg::AXIS_X, 0),
            '{16'd32768, 16'd32768, 16'sd0, 16'sd0, 16'sd32767}));
        table_rows.push_back(fixed_row(
            row(drc_pkg::REQ_CONVERT, 0, 0, -8388608, 0, 0, drc_pkg::AXIS_X, 0),
            '{16'd0, 16'd32768, 16'sd0, 16'sd0, 16'h8000}));
        table_rows.push_back(row(drc_pkg::REQ_CONVERT, 8388607, 8388607, 8388607, 0, 0,
                                 drc_pkg::AXIS_X, 0));
        table_rows.push_back(row(drc_pkg::REQ_CONVERT, -8388608, -8388608, -8388608, 0, 0,
                                 drc_pkg::AXIS_Y, 0));
        table_rows.push_back(row(drc_pkg::REQ_CONVERT, 1, 0, 0, 0, 0, drc_pkg::AXIS_X, 0));
        table_rows.push_back(row(drc_pkg::REQ_CONVERT, -1, 0, 0, 0, 0, drc_pkg::AXIS_X, 0));
        table_rows.push_back(row(drc_pkg::REQ_CONVERT, 0, -1, 0, 0, 0, drc_pkg::AXIS_X, 0));
        table_rows.push_back(row(drc_pkg::REQ_CONVERT, 1, -1, 1, 65535, 65535,
                                 drc_pkg::AXIS_NONE, 65535));
        table_rows.push_back(row(drc_pkg::REQ_ROTATE, 0, 0, 0, 0, 0, drc_pkg::AXIS_NONE, 0));
        table_rows.push_back(row(drc_pkg::REQ_ROTATE, 0, 0, 0, 32768, 0, drc_pkg::AXIS_X, 0));
        table_rows.push_back(row(drc_pkg::REQ_ROTATE, 0, 0, 0, 16384, 65535,
                                 drc_pkg::AXIS_X, 16384));
        table_rows.push_back(row(drc_pkg::REQ_ROTATE, 0, 0, 0, 16384, 16384,
                                 drc_pkg::AXIS_Y, 32768));
        table_rows.push_back(row(drc_pkg::REQ_ROTATE, 0, 0, 0, 8192, 40000,
                                 drc_pkg::AXIS_Z, 65535));
        table_rows.push_back(row(drc_pkg::REQ_ROTATE, 0, 0, 0, 8192, 40000,
                                 drc_pkg::AXIS_NONE, 12345));
        table_rows.push_back(row(drc_pkg::REQ_ROTATE, 0, 0, 0, 65535, 1, drc_pkg::AXIS_Y, 1));
        table_rows.push_back(row(drc_pkg::REQ_ROTATE, -1, -1, -1, 40000, 0,
                                 drc_pkg::AXIS_Z, 49152));
        foreach (table_rows[i])
            send_request(table_rows[i]);

        for (int n = 0; n < 1000; n++)
        begin
            steady = (n >= 400 && n < 600);
            send_request(random_row());
        end
        in_valid <= 1'b0;
        steady = 0;

        while (pending_dirs.size() != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
